[rtl/core/lpc_pkg.sv]
// Shared types, constants and the sequencer state type for the line position centroid block.
`default_nettype none

package lpc_pkg;

	localparam int SLOTS        = 5;
	localparam int CHANNELS_DEF = 5;
	localparam int SAMPLE_W     = 10;
	localparam int MIN_W        = 10;
	localparam int RANGE_W      = 11;
	localparam int LEVEL_W      = 11;
	localparam int POS_W        = 13;
	localparam int COUNT_W      = 3;
	localparam int CH_IDX_W     = 3;
	localparam int SUM_W        = 13;
	localparam int WSUM_W       = 14;
	localparam int FRAC_BITS    = 10;
	localparam int DIV_NUM_W    = 24;
	localparam int DIV_DEN_W    = 13;
	localparam int MINS_W       = SLOTS * MIN_W;
	localparam int RANGES_W     = SLOTS * RANGE_W;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_ADDR_W   = 4;

	localparam logic [LEVEL_W-1:0]  FULL_SCALE   = 11'd1024;
	localparam logic [LEVEL_W-1:0]  SENSE_LEVEL  = 11'd512;
	localparam logic [POS_W-1:0]    POS_MAX      = 13'd4096;
	localparam logic [RANGES_W-1:0] RANGES_RESET = {SLOTS{11'd1024}};

	// register index codes, taken from paddr[3]
	localparam logic REG_MINS   = 1'b0;
	localparam logic REG_RANGES = 1'b1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_zero;
		logic [SAMPLE_W-1:0] sample_one;
		logic [SAMPLE_W-1:0] sample_two;
		logic [SAMPLE_W-1:0] sample_three;
		logic [SAMPLE_W-1:0] sample_four;
	} sample_t;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] sensing_count;
		logic [LEVEL_W-1:0] level_zero;
		logic [LEVEL_W-1:0] level_one;
		logic [LEVEL_W-1:0] level_two;
		logic [LEVEL_W-1:0] level_three;
		logic [LEVEL_W-1:0] level_four;
	} result_t;

	typedef struct packed {
		logic [MINS_W-1:0]   mins;
		logic [RANGES_W-1:0] ranges;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_NWAIT,
		ST_CENT,
		ST_CWAIT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[rtl/core/line_position_centroid.sv]
// Top level: sample normalization and weighted centroid on one shared divider.
`default_nettype none

// A sample word takes one normalizing division per channel and one centroid division, all
// on a single radix-4 divider; a channel at or below its minimum or with a zero range skips
// the divider. sample_ready is high only while the sequencer is idle; one finished result
// can wait in the output register while the next word is accepted. When no channel reads
// above half scale the previous position is repeated.
module line_position_centroid #(
	parameter int CHANNELS = lpc_pkg::CHANNELS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           sample_valid,
	output logic                                sample_ready,
	input  wire lpc_pkg::sample_t               samples,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output lpc_pkg::result_t                    result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [lpc_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [lpc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [lpc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready
);
	import lpc_pkg::*;

	localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(CHANNELS - 1);

	cfg_t cfg;

	state_t state_q, state_d;

	logic [SAMPLE_W-1:0] samp_q  [SLOTS];
	logic [LEVEL_W-1:0]  level_q [SLOTS];
	logic [MIN_W-1:0]    mn_arr  [SLOTS];
	logic [RANGE_W-1:0]  rg_arr  [SLOTS];
	logic [CH_IDX_W-1:0] ch_q;
	logic [SUM_W-1:0]    sum_q;
	logic [WSUM_W-1:0]   wacc_q;
	logic [COUNT_W-1:0]  count_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    held_q;
	result_t             res_q;
	logic                res_valid_q;

	logic                   accept;
	logic [SAMPLE_W-1:0]    raw;
	logic [MIN_W-1:0]       mn;
	logic [RANGE_W-1:0]     rg;
	logic [SAMPLE_W-1:0]    diff;
	logic                   acc_en;
	logic [LEVEL_W-1:0]     acc_lvl;
	logic                   pos_ld;
	logic [POS_W-1:0]       pos_nxt;
	logic                   res_ld;
	logic                   div_start;
	logic [DIV_NUM_W-1:0]   div_num;
	logic [DIV_DEN_W-1:0]   div_den;
	logic                   div_busy;
	logic                   div_done;
	logic [DIV_NUM_W-1:0]   div_quo;
	logic [LEVEL_W-1:0]     quo_clamped;

	lpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lpc_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (DIV_DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			mn_arr[k] = cfg.mins[k*MIN_W +: MIN_W];
			rg_arr[k] = cfg.ranges[k*RANGE_W +: RANGE_W];
		end
	end

	assign raw          = samp_q[ch_q];
	assign mn           = mn_arr[ch_q];
	assign rg           = rg_arr[ch_q];
	assign diff         = raw - mn;
	assign quo_clamped  = (div_quo > DIV_NUM_W'(FULL_SCALE)) ? FULL_SCALE : div_quo[LEVEL_W-1:0];
	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid & sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		acc_en    = 1'b0;
		acc_lvl   = '0;
		pos_ld    = 1'b0;
		pos_nxt   = held_q;
		res_ld    = 1'b0;
		div_start = 1'b0;
		div_num   = {{(DIV_NUM_W-SAMPLE_W-FRAC_BITS){1'b0}}, diff, {FRAC_BITS{1'b0}}};
		div_den   = DIV_DEN_W'(rg);
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (raw <= mn) begin
					acc_en = 1'b1;
				end else if (rg == '0) begin
					acc_en  = 1'b1;
					acc_lvl = FULL_SCALE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_NWAIT;
				end
				if (acc_en && ch_q == LAST_CH) state_d = ST_CENT;
			end
			ST_NWAIT: begin
				if (div_done) begin
					acc_en  = 1'b1;
					acc_lvl = quo_clamped;
					state_d = (ch_q == LAST_CH) ? ST_CENT : ST_NORM;
				end
			end
			ST_CENT: begin
				if (count_q == '0 || sum_q == '0) begin
					pos_ld  = 1'b1;
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					div_num   = {wacc_q, {FRAC_BITS{1'b0}}};
					div_den   = sum_q;
					state_d   = ST_CWAIT;
				end
			end
			ST_CWAIT: begin
				if (div_done) begin
					pos_ld  = 1'b1;
					pos_nxt = div_quo[POS_W-1:0];
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_valid_q || result_ready) begin
					res_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			held_q      <= '0;
		end else begin
			if (res_ld) begin
				res_valid_q <= 1'b1;
				held_q      <= pos_q;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q[0] <= samples.sample_zero;
			samp_q[1] <= samples.sample_one;
			samp_q[2] <= samples.sample_two;
			samp_q[3] <= samples.sample_three;
			samp_q[4] <= samples.sample_four;
			for (int k = 0; k < SLOTS; k++) level_q[k] <= '0;
			ch_q    <= '0;
			sum_q   <= '0;
			wacc_q  <= '0;
			count_q <= '0;
		end else if (acc_en) begin
			level_q[ch_q] <= acc_lvl;
			sum_q         <= sum_q + SUM_W'(acc_lvl);
			wacc_q        <= WSUM_W'(wacc_q + WSUM_W'(ch_q) * WSUM_W'(acc_lvl));
			count_q       <= count_q + COUNT_W'(acc_lvl > SENSE_LEVEL);
			// hold the index on the last channel
			if (ch_q != LAST_CH) ch_q <= ch_q + 1'b1;
		end
		if (pos_ld) pos_q <= pos_nxt;
		if (res_ld) begin
			res_q.position      <= pos_q;
			res_q.sensing_count <= count_q;
			res_q.level_zero    <= level_q[0];
			res_q.level_one     <= level_q[1];
			res_q.level_two     <= level_q[2];
			res_q.level_three   <= level_q[3];
			res_q.level_four    <= level_q[4];
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_wait_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_NWAIT || state_q == ST_CWAIT) && !div_busy) |-> div_done)
		else $error("waiting on an idle divider with no quotient");

	a_acc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_en |-> (ch_q <= LAST_CH))
		else $error("level accumulated for an unused channel");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.position <= POS_MAX))
		else $error("position above full scale");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.sensing_count <= COUNT_W'(CHANNELS)))
		else $error("sensing count above channel count");

endmodule

`default_nettype wire

[rtl/core/lpc_div.sv]
// Shared restoring divider, two quotient bits per cycle.
`default_nettype none

module lpc_div #(
	parameter int NUM_W = lpc_pkg::DIV_NUM_W,
	parameter int DEN_W = lpc_pkg::DIV_DEN_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);
	import lpc_pkg::*;

	localparam int STEPS  = NUM_W / 2;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0]    trial_a;
	logic [DEN_W:0]    trial_b;
	logic              ge_a;
	logic              ge_b;
	logic [DEN_W-1:0]  rem_a;
	logic [DEN_W-1:0]  rem_b;
	logic [NUM_W-1:0]  num_a;
	logic [NUM_W-1:0]  num_b;

	// two dependent compare-subtract steps; quotient bits shift in behind the dividend
	always_comb begin
		trial_a = {rem_q, num_q[NUM_W-1]};
		ge_a    = trial_a >= {1'b0, den_q};
		rem_a   = ge_a ? DEN_W'(trial_a - {1'b0, den_q}) : trial_a[DEN_W-1:0];
		num_a   = {num_q[NUM_W-2:0], ge_a};
		trial_b = {rem_a, num_a[NUM_W-1]};
		ge_b    = trial_b >= {1'b0, den_q};
		rem_b   = ge_b ? DEN_W'(trial_b - {1'b0, den_q}) : trial_b[DEN_W-1:0];
		num_b   = {num_a[NUM_W-2:0], ge_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_b;
			num_q <= num_b;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q;

endmodule

`default_nettype wire

[rtl/core/lpc_regs.sv]
// APB configuration registers: channel minimums and channel ranges.
`default_nettype none

module lpc_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lpc_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [lpc_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [lpc_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output lpc_pkg::cfg_t                        cfg
);
	import lpc_pkg::*;

	logic [MINS_W-1:0]   mins_q;
	logic [RANGES_W-1:0] ranges_q;
	logic                wr_en;
	logic                reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mins_q   <= '0;
			ranges_q <= RANGES_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MINS:   mins_q   <= pwdata[MINS_W-1:0];
				REG_RANGES: ranges_q <= pwdata[RANGES_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MINS:   prdata = CFG_DATA_W'(mins_q);
			REG_RANGES: prdata = CFG_DATA_W'(ranges_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.mins   = mins_q;
	assign cfg.ranges = ranges_q;

endmodule

`default_nettype wire
